>>> src/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types, constants and controller encodings of the polygon plane
// clipper.
// ----------------------------------------------------------------------------
package ppc_pkg;

	localparam int MAX_VERTICES_DEF = 16;
	localparam int COORD_W = 32;
	localparam int ACC_W   = 66;
	localparam int DIST_W  = 50;
	localparam int DEN_W   = 51;
	localparam int TQ_W    = 32;
	localparam int BAND_W  = 31;

	localparam logic [1:0] MARK_BOUNDARY = 2'd0;
	localparam logic [1:0] MARK_INSIDE   = 2'd1;
	localparam logic [1:0] MARK_OUTSIDE  = 2'd2;

	typedef enum logic [2:0] {
		REG_NORMAL_X,
		REG_NORMAL_Y,
		REG_NORMAL_Z,
		REG_PLANE_OFFSET,
		REG_BOUNDARY_BAND
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} vertex_t;

	typedef struct packed {
		logic [1:0] mark;
		vertex_t    v;
	} entry_t;

	typedef struct packed {
		logic    overflowed;
		logic    empty_polygon;
		vertex_t v;
	} result_t;

	typedef enum logic [1:0] {
		SRC_VIN,
		SRC_A,
		SRC_B
	} dist_src_t;

	typedef enum logic [1:0] {
		PUT_CUR,
		PUT_PT,
		PUT_ZERO
	} put_src_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_IN,
		S_INW,
		S_DECIDE,
		S_EMPTY,
		S_PRD,
		S_PLD,
		S_CRD,
		S_EVAL,
		S_XB,
		S_XBW,
		S_XA,
		S_XAW,
		S_XD,
		S_XDW,
		S_XM,
		S_XMW,
		S_PPT,
		S_PCUR,
		S_NEXT,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic      in_ready;
		logic      dist_go;
		dist_src_t dist_src;
		logic      classify;
		logic      ovf_set;
		logic      rd_prev;
		logic      rd_cur;
		logic      prev_load;
		logic      x_set;
		logic      x_swap;
		logic      db_cap;
		logic      den_cap;
		logic      div_go;
		logic      mul_go;
		logic      put;
		put_src_t  put_src;
		logic      flush;
		logic      idx_clr;
		logic      idx_inc;
	} ctrl_cmd_t;

	typedef struct packed {
		logic       cnt_full;
		logic       outs_zero;
		logic       ins_zero;
		logic       dist_done;
		logic       div_done;
		logic       mul_done;
		logic       can_put;
		logic       can_flush;
		logic       idx_last;
		logic       vin_last;
		logic [1:0] cur_mark;
		logic [1:0] prev_mark;
	} dp_status_t;

endpackage

>>> src/ppc_datapath.sv
// ----------------------------------------------------------------------------
// ppc_datapath
// Registers, vertex memory, plane distance unit, restoring divider,
// interpolation multiplier and output staging of the clipper.
// ----------------------------------------------------------------------------
module ppc_datapath #(
	parameter int MAX_VERTICES = ppc_pkg::MAX_VERTICES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	input  ppc_pkg::vertex_t     in_vertex,
	input  logic                 in_last,
	output ppc_pkg::result_t     out_res,
	output logic                 out_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  ppc_pkg::ctrl_cmd_t   cmd,
	output ppc_pkg::dp_status_t  status
);
	import ppc_pkg::*;

	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int AW = $clog2(MAX_VERTICES);

	logic signed [COORD_W-1:0] nx_q, ny_q, nz_q, off_q;
	logic [BAND_W-1:0]         band_q;

	vertex_t vin_q;
	logic    vin_last_q;

	entry_t  mem_q [MAX_VERTICES];
	entry_t  rd_q;
	entry_t  prev_q;
	logic [CW-1:0] cnt_q, ins_q, outs_q;
	logic [CW-1:0] cnt_m1;
	logic          ovf_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] raddr;

	vertex_t a_q, b_q, dop_q, pt_q;

	logic                     dist_run_q;
	logic [2:0]               dist_k_q;
	logic signed [63:0]       prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DIST_W-1:0] dist_q;
	logic signed [COORD_W-1:0] mul_a, mul_b;

	logic signed [DIST_W-1:0] band_s, nband_s;
	logic [1:0]               new_mark;

	logic signed [DIST_W-1:0] db_q;
	logic signed [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]         num_abs, den_abs;
	logic                     div_ok;
	logic [DEN_W:0]           r_q, r2;
	logic [DEN_W-1:0]         dm_q;
	logic [TQ_W-1:0]          tq_q;
	logic                     full_q;
	logic [5:0]               div_cnt_q;
	logic                     div_run_q;

	logic                     mul_run_q;
	logic [2:0]               mc_q;
	logic signed [COORD_W:0]  dv;
	logic                     dv_neg;
	logic [COORD_W:0]         dv_mag;
	logic [64:0]              mprod_q;
	logic                     mneg_q;
	logic [65:0]              rsum;
	logic signed [34:0]       roff;
	logic signed [COORD_W-1:0] fin_a, fin_b, fin_res;
	logic signed [COORD_W-1:0] sel_a, sel_b;

	result_t hold_q, new_res;
	logic    hold_v_q;
	result_t out_q;
	logic    out_last_q, out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q   <= '0;
			ny_q   <= '0;
			nz_q   <= 32'sd65536;
			off_q  <= '0;
			band_q <= 31'd66;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_NORMAL_X:      nx_q   <= cfg_data;
				REG_NORMAL_Y:      ny_q   <= cfg_data;
				REG_NORMAL_Z:      nz_q   <= cfg_data;
				REG_PLANE_OFFSET:  off_q  <= cfg_data;
				REG_BOUNDARY_BAND: band_q <= cfg_data[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_ready && in_valid) begin
			vin_q      <= in_vertex;
			vin_last_q <= in_last;
		end
	end

	always_comb begin
		unique case (dist_k_q)
			3'd0:    begin mul_a = nx_q; mul_b = dop_q.x; end
			3'd1:    begin mul_a = ny_q; mul_b = dop_q.y; end
			default: begin mul_a = nz_q; mul_b = dop_q.z; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_run_q <= 1'b0;
			dist_k_q   <= '0;
		end else if (cmd.dist_go) begin
			dist_run_q <= 1'b1;
			dist_k_q   <= '0;
		end else if (dist_run_q) begin
			dist_k_q <= dist_k_q + 3'd1;
			if (dist_k_q == 3'd5) begin
				dist_run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dist_go) begin
			unique case (cmd.dist_src)
				SRC_A:   dop_q <= a_q;
				SRC_B:   dop_q <= b_q;
				default: dop_q <= vin_q;
			endcase
		end
		prod_q <= mul_a * mul_b;
		if (dist_run_q) begin
			unique case (dist_k_q)
				3'd1:      acc_q <= ACC_W'(prod_q);
				3'd2, 3'd3: acc_q <= acc_q + ACC_W'(prod_q);
				3'd4:      dist_q <= DIST_W'(acc_q >>> 16) + DIST_W'(off_q);
				default: ;
			endcase
		end
	end

	assign band_s  = {{(DIST_W-BAND_W){1'b0}}, band_q};
	assign nband_s = -band_s;

	always_comb begin
		if (dist_q > band_s) begin
			new_mark = MARK_INSIDE;
		end else if (dist_q < nband_s) begin
			new_mark = MARK_OUTSIDE;
		end else begin
			new_mark = MARK_BOUNDARY;
		end
	end

	assign cnt_m1 = cnt_q - CW'(1);
	assign raddr  = cmd.rd_prev ? cnt_m1[AW-1:0] : idx_q;

	always_ff @(posedge clk) begin
		if (cmd.classify) begin
			mem_q[cnt_q[AW-1:0]] <= '{mark: new_mark, v: vin_q};
		end
		if (cmd.rd_prev || cmd.rd_cur) begin
			rd_q <= mem_q[raddr];
		end
		if (cmd.prev_load) begin
			prev_q <= rd_q;
		end
		if (cmd.x_set) begin
			a_q <= cmd.x_swap ? rd_q.v : prev_q.v;
			b_q <= cmd.x_swap ? prev_q.v : rd_q.v;
		end
		if (cmd.db_cap) begin
			db_q <= dist_q;
		end
		if (cmd.den_cap) begin
			den_q <= DEN_W'(db_q) - DEN_W'(dist_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ins_q  <= '0;
			outs_q <= '0;
			ovf_q  <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (cmd.classify) begin
				cnt_q <= cnt_q + CW'(1);
				if (new_mark == MARK_INSIDE) begin
					ins_q <= ins_q + CW'(1);
				end
				if (new_mark == MARK_OUTSIDE) begin
					outs_q <= outs_q + CW'(1);
				end
			end
			if (cmd.ovf_set) begin
				ovf_q <= 1'b1;
			end
			if (cmd.flush) begin
				cnt_q  <= '0;
				ins_q  <= '0;
				outs_q <= '0;
				ovf_q  <= 1'b0;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	assign num_abs = db_q[DIST_W-1] ? DEN_W'(-db_q) : DEN_W'(db_q);
	assign den_abs = den_q[DEN_W-1] ? DEN_W'(-den_q) : DEN_W'(den_q);
	assign div_ok  = (den_q != '0) && (db_q != '0) && (db_q[DIST_W-1] == den_q[DEN_W-1]);
	assign r2      = {r_q[DEN_W-1:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_run_q <= 1'b0;
			div_cnt_q <= '0;
		end else if (cmd.div_go) begin
			div_run_q <= 1'b1;
			div_cnt_q <= (div_ok && (num_abs < den_abs)) ? 6'd32 : 6'd0;
		end else if (div_run_q) begin
			if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 6'd1;
			end else begin
				div_run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_go) begin
			r_q    <= {1'b0, num_abs};
			dm_q   <= den_abs;
			tq_q   <= '0;
			full_q <= div_ok && (num_abs >= den_abs);
		end else if (div_run_q && (div_cnt_q != '0)) begin
			if (r2 >= {1'b0, dm_q}) begin
				r_q  <= r2 - {1'b0, dm_q};
				tq_q <= {tq_q[TQ_W-2:0], 1'b1};
			end else begin
				r_q  <= r2;
				tq_q <= {tq_q[TQ_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		unique case (mc_q)
			3'd0:    begin sel_a = a_q.x; sel_b = b_q.x; end
			3'd1:    begin sel_a = a_q.y; sel_b = b_q.y; end
			default: begin sel_a = a_q.z; sel_b = b_q.z; end
		endcase
		unique case (mc_q)
			3'd1:    begin fin_a = a_q.x; fin_b = b_q.x; end
			3'd2:    begin fin_a = a_q.y; fin_b = b_q.y; end
			default: begin fin_a = a_q.z; fin_b = b_q.z; end
		endcase
	end

	assign dv      = (COORD_W+1)'(sel_b) - (COORD_W+1)'(sel_a);
	assign dv_neg  = dv[COORD_W];
	assign dv_mag  = dv_neg ? (COORD_W+1)'(-dv) : dv;
	assign rsum    = {1'b0, mprod_q} + 66'h0_8000_0000;
	assign roff    = mneg_q ? -$signed({1'b0, rsum[65:32]}) : $signed({1'b0, rsum[65:32]});
	assign fin_res = full_q ? fin_a : COORD_W'(35'(fin_b) - roff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_run_q <= 1'b0;
			mc_q      <= '0;
		end else if (cmd.mul_go) begin
			mul_run_q <= 1'b1;
			mc_q      <= '0;
		end else if (mul_run_q) begin
			if (mc_q == 3'd4) begin
				mul_run_q <= 1'b0;
			end else begin
				mc_q <= mc_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		mprod_q <= 65'(dv_mag) * 65'(tq_q);
		mneg_q  <= dv_neg;
		if (mul_run_q) begin
			unique case (mc_q)
				3'd1:    pt_q.x <= fin_res;
				3'd2:    pt_q.y <= fin_res;
				3'd3:    pt_q.z <= fin_res;
				default: ;
			endcase
		end
	end

	always_comb begin
		new_res = '{overflowed: ovf_q, empty_polygon: 1'b0, v: rd_q.v};
		unique case (cmd.put_src)
			PUT_PT:   new_res.v = pt_q;
			PUT_ZERO: begin
				new_res.v             = '0;
				new_res.empty_polygon = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (cmd.put) begin
				hold_v_q <= 1'b1;
				if (hold_v_q) begin
					out_v_q    <= 1'b1;
					out_last_q <= 1'b0;
				end else if (out_v_q && out_ready) begin
					out_v_q <= 1'b0;
				end
			end else if (cmd.flush) begin
				hold_v_q   <= 1'b0;
				out_v_q    <= 1'b1;
				out_last_q <= 1'b1;
			end else if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			hold_q <= new_res;
			if (hold_v_q) begin
				out_q <= hold_q;
			end
		end else if (cmd.flush) begin
			out_q <= hold_q;
		end
	end

	assign out_res   = out_q;
	assign out_last  = out_last_q;
	assign out_valid = out_v_q;

	always_comb begin
		status.cnt_full  = (cnt_q == CW'(MAX_VERTICES));
		status.outs_zero = (outs_q == '0);
		status.ins_zero  = (ins_q == '0);
		status.dist_done = dist_run_q && (dist_k_q == 3'd5);
		status.div_done  = div_run_q && (div_cnt_q == '0);
		status.mul_done  = mul_run_q && (mc_q == 3'd4);
		status.can_put   = !hold_v_q || !out_v_q || out_ready;
		status.can_flush = !out_v_q || out_ready;
		status.idx_last  = (idx_q == cnt_m1[AW-1:0]);
		status.vin_last  = vin_last_q;
		status.cur_mark  = rd_q.mark;
		status.prev_mark = prev_q.mark;
	end

endmodule

>>> src/ppc_ctrl.sv
// ----------------------------------------------------------------------------
// ppc_ctrl
// Controller of the clipper: vertex intake, polygon decision and the walk
// that emits kept vertices and crossing points.
// ----------------------------------------------------------------------------
module ppc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  ppc_pkg::dp_status_t  status,
	output ppc_pkg::ctrl_cmd_t   cmd
);
	import ppc_pkg::*;

	state_t state_q, state_d;
	logic   cur_out, cur_in, prev_out, prev_in;

	assign cur_out  = (status.cur_mark == MARK_OUTSIDE);
	assign cur_in   = (status.cur_mark == MARK_INSIDE);
	assign prev_out = (status.prev_mark == MARK_OUTSIDE);
	assign prev_in  = (status.prev_mark == MARK_INSIDE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_IN;
			S_IN: begin
				if (!status.cnt_full) begin
					state_d = S_INW;
				end else if (status.vin_last) begin
					state_d = S_DECIDE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_INW: begin
				if (status.dist_done) begin
					state_d = status.vin_last ? S_DECIDE : S_IDLE;
				end
			end
			S_DECIDE: begin
				if (!status.outs_zero && status.ins_zero) begin
					state_d = S_EMPTY;
				end else begin
					state_d = S_PRD;
				end
			end
			S_EMPTY:  if (status.can_put) state_d = S_FLUSH;
			S_PRD:    state_d = S_PLD;
			S_PLD:    state_d = S_CRD;
			S_CRD:    state_d = S_EVAL;
			S_EVAL: begin
				priority if ((cur_out && prev_in) || (cur_in && prev_out)) begin
					state_d = S_XB;
				end else if (cur_out) begin
					state_d = S_NEXT;
				end else begin
					state_d = S_PCUR;
				end
			end
			S_XB:     state_d = S_XBW;
			S_XBW:    if (status.dist_done) state_d = S_XA;
			S_XA:     state_d = S_XAW;
			S_XAW:    if (status.dist_done) state_d = S_XD;
			S_XD:     state_d = S_XDW;
			S_XDW:    if (status.div_done) state_d = S_XM;
			S_XM:     state_d = S_XMW;
			S_XMW:    if (status.mul_done) state_d = S_PPT;
			S_PPT: begin
				if (status.can_put) begin
					state_d = cur_out ? S_NEXT : S_PCUR;
				end
			end
			S_PCUR:   if (status.can_put) state_d = S_NEXT;
			S_NEXT:   state_d = status.idx_last ? S_FLUSH : S_CRD;
			S_FLUSH:  if (status.can_flush) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.dist_src = SRC_VIN;
		cmd.put_src  = PUT_CUR;
		unique case (state_q)
			S_IDLE:   cmd.in_ready = 1'b1;
			S_IN: begin
				cmd.dist_go = !status.cnt_full;
				cmd.ovf_set = status.cnt_full;
			end
			S_INW:    cmd.classify = status.dist_done;
			S_DECIDE: cmd.idx_clr = 1'b1;
			S_EMPTY: begin
				cmd.put     = status.can_put;
				cmd.put_src = PUT_ZERO;
			end
			S_PRD:    cmd.rd_prev = 1'b1;
			S_PLD:    cmd.prev_load = 1'b1;
			S_CRD:    cmd.rd_cur = 1'b1;
			S_EVAL: begin
				cmd.x_set  = 1'b1;
				cmd.x_swap = !cur_out;
			end
			S_XB: begin
				cmd.dist_go  = 1'b1;
				cmd.dist_src = SRC_B;
			end
			S_XBW:    cmd.db_cap = status.dist_done;
			S_XA: begin
				cmd.dist_go  = 1'b1;
				cmd.dist_src = SRC_A;
			end
			S_XAW:    cmd.den_cap = status.dist_done;
			S_XD:     cmd.div_go = 1'b1;
			S_XM:     cmd.mul_go = 1'b1;
			S_PPT: begin
				cmd.put     = status.can_put;
				cmd.put_src = PUT_PT;
			end
			S_PCUR:   cmd.put = status.can_put;
			S_NEXT: begin
				cmd.prev_load = 1'b1;
				cmd.idx_inc   = 1'b1;
			end
			S_FLUSH:  cmd.flush = status.can_flush;
			default: ;
		endcase
	end

endmodule

>>> src/polygon_plane_clipper_core.sv
// ----------------------------------------------------------------------------
// polygon_plane_clipper_core
// Clips one polygon at a time against a configurable plane with a boundary
// band, emitting kept vertices and interpolated crossing points.
//
// Channel   Dir  Handshake              Content
// s_axis    in   s_axis_tvalid/tready   vertex x, y, z; tlast ends polygon
// m_axis    out  m_axis_tvalid/tready   vertex x, y, z; tlast, tuser flags
// cfg       in   cfg_valid/cfg_ready    register index and write data
//
// A stored vertex passes the shared 32 x 32 multiplier of the plane distance
// unit at intake; a dropped one, arriving with the memory full, skips it.
// During emission each crossing point takes two distance passes, a divide
// and three multiplies before the point is emitted.
// Reset clears the control state; the vertex memory needs no clearing.
// A stalled output holds one result in the output register and one in the
// staging register; the walk waits until a slot frees up.
// ----------------------------------------------------------------------------
module polygon_plane_clipper_core #(
	parameter int MAX_VERTICES = ppc_pkg::MAX_VERTICES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // vertex_x, vertex_y, vertex_z
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // out_x, out_y, out_z
	output logic        m_axis_tlast,
	output logic [1:0]  m_axis_tuser,  // empty_polygon, overflowed
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import ppc_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	result_t    res;

	ppc_datapath #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_vertex (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_res   (res),
		.out_last  (m_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.status    (status)
	);

	ppc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.status   (status),
		.cmd      (cmd)
	);

	assign s_axis_tready = cmd.in_ready;
	assign m_axis_tdata  = res.v;
	assign m_axis_tuser  = {res.overflowed, res.empty_polygon};
	assign cfg_ready     = 1'b1;

endmodule

>>> src/ppc_checker.sv
// ----------------------------------------------------------------------------
// ppc_port_checks
// Port-level checks of the clipper output stream.
// ----------------------------------------------------------------------------
module ppc_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [1:0]  m_axis_tuser
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped during a stall");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			$stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("output transaction changed during a stall");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
		else $error("empty marker is not the final transaction");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 96'd0)
		else $error("empty marker carries coordinates");

endmodule

bind polygon_plane_clipper_core ppc_port_checks u_ppc_port_checks (.*);
